// ----- design/bcet_pkg.sv -----
// Package for the blocky colour edge tile unit.
// Holds field widths, register index codes, and the edge and saturating-sum functions.
// Used by every module in this folder.
package bcet_pkg;

    localparam int PIX_W      = 24;
    localparam int EDGE_W     = 24;
    localparam int TILE_W     = 25;
    localparam int ROW_W      = 10;
    localparam int OUT_COL_W  = 9;
    localparam int CFG_COLS_W = 10;
    localparam int CFG_ROWS_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_ROWS = 1'b1;

    localparam logic [CFG_COLS_W-1:0] COLS_RESET = 10'd160;
    localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 11'd120;
    localparam logic [CFG_ROWS_W-1:0] ROW_LIMIT  = 11'd1024;

    localparam logic [10:0]       HI_LIMIT   = 11'd127;
    localparam logic [11:0]       LO_LIMIT   = 12'd255;
    localparam logic [TILE_W-1:0] CARRY_MASK = 25'h1010100;

    // Position flags handed from the scan counters to the pipeline.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             interior;
    } t_pos;

    // Write-back of one left-edge entry into the row store.
    typedef struct packed {
        logic              en;
        logic [EDGE_W-1:0] data;
    } t_wb;

    function automatic logic [15:0] chan_square(input logic [7:0] a, input logic [7:0] b);
        logic signed [8:0]  d;
        logic signed [17:0] p;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        p = d * d;
        return p[15:0];
    endfunction

    function automatic logic [6:0] term_hi(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] sq;
        logic [10:0] t;
        sq = chan_square(a, b);
        t  = sq[15:5];
        return (t > HI_LIMIT) ? HI_LIMIT[6:0] : t[6:0];
    endfunction

    function automatic logic [7:0] term_lo(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] sq;
        logic [11:0] t;
        sq = chan_square(a, b);
        t  = sq[15:4];
        return (t > LO_LIMIT) ? LO_LIMIT[7:0] : t[7:0];
    endfunction

    function automatic logic [EDGE_W-1:0] edge_of(input logic [PIX_W-1:0] p,
                                                  input logic [PIX_W-1:0] q);
        return {term_hi(p[23:16], q[23:16]), 1'b0,
                term_hi(p[15:8], q[15:8]), 1'b0,
                term_lo(p[7:0], q[7:0])};
    endfunction

    // Carries out of each field are spread back over that field to saturate it.
    function automatic logic [TILE_W-1:0] sat_sum(input logic [EDGE_W-1:0] a,
                                                  input logic [EDGE_W-1:0] b);
        logic [TILE_W-1:0] s;
        logic [TILE_W-1:0] c;
        s = {1'b0, a} + {1'b0, b};
        c = s & CARRY_MASK;
        return s | (c - (c >> 8));
    endfunction

endpackage

// ----- design/bcet_scan.sv -----
// Configuration registers and raster position counters of the edge tile unit.
// Depends on bcet_pkg.
module bcet_scan import bcet_pkg::*; #(
    parameter int MAX_CELL_COLS = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_ROWS_W-1:0]         i_cfg_data,
    input  logic                          i_step,
    output logic [$clog2(MAX_CELL_COLS)-1:0] o_col,
    output t_pos                          o_pos
);

    localparam int AW = $clog2(MAX_CELL_COLS);
    localparam int PW = (AW + 1 > CFG_COLS_W) ? AW + 1 : CFG_COLS_W;

    logic [CFG_COLS_W-1:0] r_cell_cols;
    logic [CFG_ROWS_W-1:0] r_cell_rows;
    logic [AW-1:0]         r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;

    logic [PW-1:0]         cols_ext, eff_cols, col_next;
    logic [CFG_ROWS_W-1:0] eff_rows, row_next;

    always_comb begin
        cols_ext = PW'(r_cell_cols);
        if (r_cell_cols == '0) begin
            eff_cols = PW'(1);
        end else if (cols_ext > PW'(MAX_CELL_COLS)) begin
            eff_cols = PW'(MAX_CELL_COLS);
        end else begin
            eff_cols = cols_ext;
        end

        if (r_cell_rows == '0) begin
            eff_rows = CFG_ROWS_W'(1);
        end else if (r_cell_rows > ROW_LIMIT) begin
            eff_rows = ROW_LIMIT;
        end else begin
            eff_rows = r_cell_rows;
        end

        col_next = PW'(r_col) + PW'(1);
        row_next = CFG_ROWS_W'(r_row) + CFG_ROWS_W'(1);

        // A cell is interior when it has a neighbor on every side.
        o_pos.interior = (r_col != '0) && (col_next < eff_cols)
                      && (r_row != '0) && (row_next < eff_rows);
        o_pos.row = r_row;

        if (col_next >= eff_cols) begin
            n_col = '0;
            n_row = (row_next >= eff_rows) ? '0 : row_next[ROW_W-1:0];
        end else begin
            n_col = col_next[AW-1:0];
            n_row = r_row;
        end
    end

    assign o_col = r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_cols <= COLS_RESET;
            r_cell_rows <= ROWS_RESET;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CELL_COLS: r_cell_cols <= i_cfg_data[CFG_COLS_W-1:0];
                    CFG_CELL_ROWS: r_cell_rows <= i_cfg_data;
                    default:       r_cell_rows <= r_cell_rows;
                endcase
            end
            if (i_step) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

// ----- design/bcet_row_store.sv -----
// Row stores of the edge tile unit: upper-row pixels and upper-row left edges.
// Synchronous memories with a registered read; depends on bcet_pkg.
module bcet_row_store import bcet_pkg::*; #(
    parameter int MAX_CELL_COLS = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rd_en,
    input  logic [$clog2(MAX_CELL_COLS)-1:0]  i_rd_col,
    input  logic [PIX_W-1:0]                  i_pixel,
    input  t_wb                               i_wb,
    input  logic [$clog2(MAX_CELL_COLS)-1:0]  i_wb_col,
    output logic [PIX_W-1:0]                  o_upper_pixel,
    output logic [EDGE_W-1:0]                 o_upper_left
);

    logic [PIX_W-1:0]  r_pix_mem  [MAX_CELL_COLS];
    logic [EDGE_W-1:0] r_edge_mem [MAX_CELL_COLS];

    logic [PIX_W-1:0]  r_rd_pixel;
    logic [EDGE_W-1:0] r_rd_edge;
    logic              r_fwd;
    logic [EDGE_W-1:0] r_fwd_data;

    // The pixel entry is read and overwritten in the same cycle; the read sees the old row.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_pixel          <= r_pix_mem[i_rd_col];
            r_pix_mem[i_rd_col] <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_edge <= r_edge_mem[i_rd_col];
        end
        if (i_wb.en) begin
            r_edge_mem[i_wb_col] <= i_wb.data;
        end
    end

    // An edge write landing in the same cycle as a read of the same entry is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wb.en && (i_wb_col == i_rd_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wb.data;
        end
    end

    assign o_upper_pixel = r_rd_pixel;
    assign o_upper_left  = r_fwd ? r_fwd_data : r_rd_edge;

endmodule

// ----- design/bcet_edge_pipe.sv -----
// Edge computation pipeline: compare stage, output register and saturating tile sums.
// Depends on bcet_pkg; reads the row store and writes left edges back into it.
module bcet_edge_pipe import bcet_pkg::*; #(
    parameter int MAX_CELL_COLS = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [PIX_W-1:0]                  i_pixel,
    input  logic [$clog2(MAX_CELL_COLS)-1:0]  i_col,
    input  t_pos                              i_pos,
    input  logic [PIX_W-1:0]                  i_upper_pixel,
    input  logic [EDGE_W-1:0]                 i_upper_left,
    output t_wb                               o_wb,
    output logic [$clog2(MAX_CELL_COLS)-1:0]  o_wb_col,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [OUT_COL_W-1:0]              o_cell_col,
    output logic [ROW_W-1:0]                  o_cell_row,
    output logic [EDGE_W-1:0]                 o_left_edge,
    output logic [EDGE_W-1:0]                 o_up_edge,
    output logic [TILE_W-1:0]                 o_tile_top_left,
    output logic [TILE_W-1:0]                 o_tile_top_second,
    output logic [TILE_W-1:0]                 o_tile_second_left,
    output logic [TILE_W-1:0]                 o_tile_second_second
);

    localparam int AW = $clog2(MAX_CELL_COLS);

    logic              accept, adv1;
    logic [PIX_W-1:0]  r_prev_pixel;
    logic [EDGE_W-1:0] r_prev_up;

    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_pixel, r_s1_prev;
    logic [AW-1:0]     r_s1_col;
    t_pos              r_s1_pos;

    logic              r_s2_valid;
    logic [AW-1:0]     r_s2_col;
    logic [ROW_W-1:0]  r_s2_row;
    logic [EDGE_W-1:0] r_s2_left, r_s2_up, r_s2_v0, r_s2_v1;

    logic [EDGE_W-1:0] left_edge, up_edge;
    logic [AW+OUT_COL_W-1:0] col_ext;

    assign adv1       = !r_s2_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || adv1;
    assign accept     = i_in_valid && o_in_ready;

    assign left_edge = edge_of(r_s1_pixel, r_s1_prev);
    assign up_edge   = edge_of(r_s1_pixel, i_upper_pixel);

    // Border cells clear their entry of the left-edge row.
    assign o_wb.en   = r_s1_valid && adv1;
    assign o_wb.data = r_s1_pos.interior ? left_edge : '0;
    assign o_wb_col  = r_s1_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_prev_pixel <= '0;
            r_prev_up    <= '0;
        end else begin
            if (accept) begin
                r_s1_valid   <= 1'b1;
                r_prev_pixel <= i_pixel;
            end else if (adv1) begin
                r_s1_valid <= 1'b0;
            end
            if (adv1) begin
                r_s2_valid <= r_s1_valid && r_s1_pos.interior;
            end
            if (o_wb.en) begin
                r_prev_up <= r_s1_pos.interior ? up_edge : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel <= i_pixel;
            r_s1_prev  <= r_prev_pixel;
            r_s1_col   <= i_col;
            r_s1_pos   <= i_pos;
        end
        if (adv1) begin
            r_s2_col  <= r_s1_col;
            r_s2_row  <= r_s1_pos.row;
            r_s2_left <= left_edge;
            r_s2_up   <= up_edge;
            r_s2_v0   <= i_upper_left;
            r_s2_v1   <= r_prev_up;
        end
    end

    assign col_ext = {{OUT_COL_W{1'b0}}, r_s2_col};

    assign o_out_valid          = r_s2_valid;
    assign o_cell_col           = col_ext[OUT_COL_W-1:0];
    assign o_cell_row           = r_s2_row;
    assign o_left_edge          = r_s2_left;
    assign o_up_edge            = r_s2_up;
    assign o_tile_top_left      = sat_sum(r_s2_v0, r_s2_v1);
    assign o_tile_top_second    = sat_sum(r_s2_v0, r_s2_up);
    assign o_tile_second_left   = sat_sum(r_s2_left, r_s2_v1);
    assign o_tile_second_second = sat_sum(r_s2_left, r_s2_up);

endmodule

// ----- design/blocky_colour_edge_tiles_unit.sv -----
// Top level of the blocky colour edge tile unit.
// Instantiates bcet_scan, bcet_row_store and bcet_edge_pipe; depends on bcet_pkg.
//
// Usage: one sampled pixel item per grid cell enters on i_in_valid/o_in_ready in
// raster order. Every interior cell (not in the first or last row or column)
// produces one result item on o_out_valid/i_out_ready carrying its position,
// the left and upper edge values and four saturating tile sums. Border cells
// are consumed and produce nothing.
// A pixel item passes the compare stage and then the output register, where its
// result is presented.
// Throughput: one item per clock while the receiver takes results. The upper-row
// stores are single memories with a registered read; a left-edge write that meets
// a read of the same entry is forwarded.
// Reset clears the position counters, the previous-cell registers and the
// pipeline; the grid size returns to 160 x 120. The row stores are not cleared:
// the first row is a border row and fills them before any interior cell reads.
// When the receiver stalls, the output register holds its item and the compare
// stage holds one more; o_in_ready drops only when both are full.
// The size registers are written on i_cfg_valid/o_cfg_ready, which is always
// ready; a write takes effect from the next pixel item on.
module blocky_colour_edge_tiles_unit import bcet_pkg::*; #(
    parameter int MAX_CELL_COLS = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_ROWS_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIX_W-1:0]      i_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_COL_W-1:0]  o_cell_col,
    output logic [ROW_W-1:0]      o_cell_row,
    output logic [EDGE_W-1:0]     o_left_edge,
    output logic [EDGE_W-1:0]     o_up_edge,
    output logic [TILE_W-1:0]     o_tile_top_left,
    output logic [TILE_W-1:0]     o_tile_top_second,
    output logic [TILE_W-1:0]     o_tile_second_left,
    output logic [TILE_W-1:0]     o_tile_second_second
);

    localparam int AW = $clog2(MAX_CELL_COLS);

    logic              accept;
    logic [AW-1:0]     col, wb_col;
    t_pos              pos;
    t_wb               wb;
    logic [PIX_W-1:0]  upper_pixel;
    logic [EDGE_W-1:0] upper_left;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    bcet_scan #(.MAX_CELL_COLS(MAX_CELL_COLS)) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (accept),
        .o_col       (col),
        .o_pos       (pos)
    );

    bcet_row_store #(.MAX_CELL_COLS(MAX_CELL_COLS)) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (accept),
        .i_rd_col      (col),
        .i_pixel       (i_pixel),
        .i_wb          (wb),
        .i_wb_col      (wb_col),
        .o_upper_pixel (upper_pixel),
        .o_upper_left  (upper_left)
    );

    bcet_edge_pipe #(.MAX_CELL_COLS(MAX_CELL_COLS)) u_pipe (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_pixel              (i_pixel),
        .i_col                (col),
        .i_pos                (pos),
        .i_upper_pixel        (upper_pixel),
        .i_upper_left         (upper_left),
        .o_wb                 (wb),
        .o_wb_col             (wb_col),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_cell_col           (o_cell_col),
        .o_cell_row           (o_cell_row),
        .o_left_edge          (o_left_edge),
        .o_up_edge            (o_up_edge),
        .o_tile_top_left      (o_tile_top_left),
        .o_tile_top_second    (o_tile_top_second),
        .o_tile_second_left   (o_tile_second_left),
        .o_tile_second_second (o_tile_second_second)
    );

endmodule

// ----- design/bcet_checker.sv -----
// Port-level checks for the blocky colour edge tile unit.
// Depends on bcet_pkg; attached to the top level by the bind below.
module bcet_checker import bcet_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_ROWS_W-1:0] i_cfg_data,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [PIX_W-1:0]      i_pixel,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [OUT_COL_W-1:0]  o_cell_col,
    input logic [ROW_W-1:0]      o_cell_row,
    input logic [EDGE_W-1:0]     o_left_edge,
    input logic [EDGE_W-1:0]     o_up_edge,
    input logic [TILE_W-1:0]     o_tile_top_left,
    input logic [TILE_W-1:0]     o_tile_top_second,
    input logic [TILE_W-1:0]     o_tile_second_left,
    input logic [TILE_W-1:0]     o_tile_second_second
);

    // A stalled result item keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_left_edge)
            && $stable(o_up_edge) && $stable(o_cell_col) && $stable(o_cell_row))
        else $error("result item changed while stalled");

    // The input side only backs up when both pipeline stages are full and stalled.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    // Results belong to interior cells only.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cell_col != '0 && o_cell_row != '0)
        else $error("result item for a border cell");

    // A carry out of the top field saturates it.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tile_second_second[24] |-> o_tile_second_second[23:16] == 8'hff)
        else $error("top field not saturated");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result item right after reset");

endmodule

bind blocky_colour_edge_tiles_unit bcet_checker u_bcet_checker (.*);
